/* src/header_timestamp_window_check_assert.svh */
// assertion macros shared by the header timestamp window check
`ifndef HEADER_TIMESTAMP_WINDOW_CHECK_ASSERT_SVH
`define HEADER_TIMESTAMP_WINDOW_CHECK_ASSERT_SVH

// same-cycle implication, off during reset
`define HTWC_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("htwc same-cycle check failed");

// next-cycle implication, off during reset
`define HTWC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("htwc next-cycle check failed");

`endif

/* src/htwc_pkg.sv */
// shared types and constants for the header timestamp window check
`timescale 1ns / 1ps

package htwc_pkg;

   localparam int WINDOW_DEF = 11;
   localparam int STAMP_W = 32;
   localparam int DRIFT_W = 16;
   localparam logic [DRIFT_W-1:0] DRIFT_RESET = 16'd7200;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CHECK  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_EMPTY     = 3'd1,
      VERDICT_NOT_AFTER = 3'd2,
      VERDICT_FUTURE    = 3'd3,
      VERDICT_DONE      = 3'd4
   } verdict_type;

   // per-cell result of the rank match
   typedef struct packed {
      logic sel;       // this cell holds the median
      logic stamp_le;  // selected and pending stamp at or below it
   } cell_stat_type;

endpackage

/* src/htwc_cell.sv */
// one ring cell: holds an ancestor time, shifts it on, ranks it against the row
`timescale 1ns / 1ps

module htwc_cell
   import htwc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF,
   parameter int INDEX  = 0
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic [STAMP_W-1:0]           shift_in,
   input  logic [STAMP_W-1:0]           row_values [WINDOW],
   input  logic [$clog2(WINDOW+1)-1:0]  count,
   input  logic [$clog2(WINDOW+1)-1:0]  half,
   input  logic [STAMP_W-1:0]           stamp,
   output logic [STAMP_W-1:0]           cell_value,
   output logic [STAMP_W-1:0]           median_part,
   output cell_stat_type                stat
);

   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [STAMP_W-1:0] value_ff;
   logic [CNT_W-1:0]   rank;
   logic               valid;

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= shift_in;
      end
   end

   assign cell_value = value_ff;
   assign valid      = CNT_W'(INDEX) < count;

   // rank among valid cells, ties broken by position so every rank is unique
   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if (j != INDEX && CNT_W'(j) < count) begin
            if (row_values[j] < value_ff || (row_values[j] == value_ff && j < INDEX)) begin
               rank = rank + 1'b1;
            end
         end
      end
   end

   assign stat.sel      = valid && (rank == half);
   assign stat.stamp_le = stat.sel && (stamp <= value_ff);
   assign median_part   = stat.sel ? value_ff : '0;

endmodule

/* src/header_timestamp_window_check.sv */
// top level of the header timestamp window check
`timescale 1ns / 1ps
`include "header_timestamp_window_check_assert.svh"

// Median-time-past check over the last WINDOW ancestor header times. Each beat on
// req_ carries an opcode: append pushes req_stamp into a row of WINDOW cells (the
// oldest time falls off the end once the row is full), clear empties the row,
// check compares req_stamp against the median of the stored times and against
// req_now_time plus the drift limit, and the unused opcode leaves the state alone.
// Every request beat yields exactly one rsp_ beat, in order, carrying the verdict
// and the median of the stored times after the request took effect (zero when
// empty). The median is the upper median for an even count. Throughput is one
// beat per cycle while rsp_ready stays high. An accepted request waits in the
// pending stage and then moves to the output register, which drives rsp_valid.
// The request is applied to the cells at the accepting edge. The cycle after that
// holds the rank match: every cell compares its time with all others at once, and
// the cell whose rank equals count/2 drives the median into the output register.
// The user writes the drift limit through csr_wr_en / csr_wr_data only while no
// request is in flight, not enforced by the block; it resets to 7200 seconds.
module header_timestamp_window_check
   import htwc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [STAMP_W-1:0] req_stamp,
   input  logic [STAMP_W-1:0] req_now_time,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_verdict,
   output logic [STAMP_W-1:0] rsp_median_time,
   // drift limit register
   input  logic               csr_wr_en,
   input  logic [DRIFT_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(WINDOW + 1);

   // drift limit
   logic [DRIFT_W-1:0] drift_ff;

   // number of filled cells; cells 0..count-1 are the valid ones
   logic [CNT_W-1:0] count_ff, count_in;

   // pending stage: request applied to the cells, median not yet taken
   logic               p_valid_ff, p_valid_in;
   op_type             p_op_ff;
   logic [STAMP_W-1:0] p_stamp_ff;
   logic [STAMP_W-1:0] p_now_ff;

   // output register
   logic               o_valid_ff, o_valid_in;
   verdict_type        verdict_ff, verdict_in;
   logic [STAMP_W-1:0] median_ff, median_in;

   logic   req_beat;
   logic   p_advance;
   logic   shift;
   op_type req_op;

   logic [STAMP_W-1:0] row_values  [WINDOW];
   logic [STAMP_W-1:0] median_part [WINDOW];
   cell_stat_type      stat        [WINDOW];
   logic [WINDOW-1:0]  sel_vec;
   logic [CNT_W-1:0]   half;

   logic               empty;
   logic               not_after;
   logic               too_far;
   logic [STAMP_W:0]   limit;

   // handshake: pending moves on when the output slot is free or being drained
   assign req_op    = op_type'(req_opcode);
   assign p_advance = !o_valid_ff || rsp_ready;
   assign req_ready = !p_valid_ff || p_advance;
   assign req_beat  = req_valid && req_ready;
   assign shift     = req_beat && (req_op == OP_APPEND);

   assign rsp_valid       = o_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_median_time = median_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff <= DRIFT_RESET;
      end else if (csr_wr_en) begin
         drift_ff <= csr_wr_data;
      end
   end

   // fill count follows the row
   always_comb begin
      count_in = count_ff;
      if (req_beat) begin
         unique case (req_op)
            OP_APPEND: begin
               if (count_ff < CNT_W'(WINDOW)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_CLEAR: count_in = '0;
            OP_CHECK,
            OP_NONE:  count_in = count_ff;
            default:  count_in = count_ff;
         endcase
      end
   end

   // row of cells: cell 0 takes the new time, each cell passes its time on
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      logic [STAMP_W-1:0] shift_in;
      if (k == 0) begin : g_head
         assign shift_in = req_stamp;
      end else begin : g_link
         assign shift_in = row_values[k-1];
      end

      htwc_cell #(
         .WINDOW (WINDOW),
         .INDEX  (k)
      ) u_cell (
         .clock       (clock),
         .shift       (shift),
         .shift_in    (shift_in),
         .row_values  (row_values),
         .count       (count_ff),
         .half        (half),
         .stamp       (p_stamp_ff),
         .cell_value  (row_values[k]),
         .median_part (median_part[k]),
         .stat        (stat[k])
      );

      assign sel_vec[k] = stat[k].sel;
   end

   assign half  = count_ff >> 1;
   assign empty = (count_ff == '0);

   // gather the selected cell's time and its compare against the stamp
   always_comb begin
      median_in = '0;
      not_after = 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
         median_in = median_in | median_part[k];
         not_after = not_after | stat[k].stamp_le;
      end
   end

   // now plus drift at 33 bits, never wraps
   assign limit   = {1'b0, p_now_ff} + {{(STAMP_W + 1 - DRIFT_W){1'b0}}, drift_ff};
   assign too_far = {1'b0, p_stamp_ff} > limit;

   always_comb begin
      verdict_in = VERDICT_DONE;
      if (p_op_ff == OP_CHECK) begin
         priority if (empty) begin
            verdict_in = VERDICT_EMPTY;
         end else if (not_after) begin
            verdict_in = VERDICT_NOT_AFTER;
         end else if (too_far) begin
            verdict_in = VERDICT_FUTURE;
         end else begin
            verdict_in = VERDICT_OK;
         end
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      if (req_beat) begin
         p_valid_in = 1'b1;
      end else if (p_advance) begin
         p_valid_in = 1'b0;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (p_advance) begin
         o_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         p_op_ff    <= req_op;
         p_stamp_ff <= req_stamp;
         p_now_ff   <= req_now_time;
      end
      if (p_advance && p_valid_ff) begin
         verdict_ff <= verdict_in;
         median_ff  <= median_in;
      end
   end

   // a non-empty row has exactly one median cell
   `HTWC_ASSERT_SAME(a_one_median, clock, reset, p_valid_ff && !empty, $onehot(sel_vec))
   // clear empties the row
   `HTWC_ASSERT_NEXT(a_clear_empties, clock, reset, req_beat && req_op == OP_CLEAR, count_ff == '0)
   // append into a row with room grows it by one
   `HTWC_ASSERT_NEXT(a_append_grows, clock, reset,
      req_beat && req_op == OP_APPEND && count_ff < CNT_W'(WINDOW),
      count_ff == $past(count_ff) + 1'b1)
   // a pending item always lands in a free output slot
   `HTWC_ASSERT_NEXT(a_pending_lands, clock, reset, p_valid_ff && !o_valid_ff, o_valid_ff)

endmodule

/* bench/header_timestamp_window_check_tb.sv */
// self-checking testbench for the header timestamp window check
`timescale 1ns / 1ps

module header_timestamp_window_check_tb;
   import htwc_pkg::*;

   localparam int WINDOW = WINDOW_DEF;

   // expected response beat: verdict plus the median after the request took effect
   typedef struct {
      verdict_type verdict;
      logic [STAMP_W-1:0] median;
   } median_verdict_type;

   // every input is known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = OP_NONE;
   logic [STAMP_W-1:0] req_stamp = '0;
   logic [STAMP_W-1:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_verdict;
   logic [STAMP_W-1:0] rsp_median_time;
   logic csr_wr_en = 1'b0;
   logic [DRIFT_W-1:0] csr_wr_data = '0;

   // shadow copy of the ancestor ring and the drift limit
   logic [STAMP_W-1:0] ring_times [WINDOW];
   int ring_fill = 0;
   int ring_next = 0;
   logic [DRIFT_W-1:0] drift_limit = DRIFT_RESET;

   median_verdict_type expected_verdicts [$];
   bit failed = 1'b0;

   // knobs shared between the test tasks and the response side
   bit idle_on = 1'b1;
   int stall_len = 0;
   // rough tip of the synthetic header chain, used to aim checks near the median
   logic [STAMP_W-1:0] chain_time;

   always #4 clock = ~clock;

   header_timestamp_window_check #(
      .WINDOW(WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_stamp(req_stamp),
      .req_now_time(req_now_time),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_verdict(rsp_verdict),
      .rsp_median_time(rsp_median_time),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // upper median of the valid ring entries, insertion sorted
   function automatic logic [STAMP_W-1:0] ring_median();
      logic [STAMP_W-1:0] sorted [WINDOW];
      logic [STAMP_W-1:0] v;
      int i;
      int j;
      if (ring_fill == 0) return '0;
      for (i = 0; i < ring_fill; i++) begin
         v = ring_times[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[ring_fill / 2];
   endfunction

   // applies one request to the shadow ring and returns the response it must produce
   function automatic median_verdict_type predict_verdict(input op_type op,
                                                          input logic [STAMP_W-1:0] stamp,
                                                          input logic [STAMP_W-1:0] now);
      median_verdict_type r;
      logic [STAMP_W:0] reach;
      r.verdict = VERDICT_DONE;
      case (op)
         OP_APPEND: begin
            // ring overwrites the oldest slot once full
            ring_times[ring_next] = stamp;
            ring_next = (ring_next == WINDOW - 1) ? 0 : ring_next + 1;
            if (ring_fill < WINDOW) ring_fill++;
            r.median = ring_median();
         end
         OP_CHECK: begin
            r.median = ring_median();
            // drift sum is kept at 33 bits so it never wraps
            reach = {1'b0, now} + (STAMP_W + 1)'(drift_limit);
            if (ring_fill == 0) r.verdict = VERDICT_EMPTY;
            else if (stamp <= r.median) r.verdict = VERDICT_NOT_AFTER;
            else if ({1'b0, stamp} > reach) r.verdict = VERDICT_FUTURE;
            else r.verdict = VERDICT_OK;
         end
         OP_CLEAR: begin
            ring_fill = 0;
            ring_next = 0;
            r.median = '0;
         end
         default: begin
            // unused opcode leaves the ring alone
            r.median = ring_median();
         end
      endcase
      return r;
   endfunction

   // one process watches both channels and the register port at every rising edge;
   // the request side is pushed first so ordering holds whatever the latency
   always @(posedge clock) begin : beat_monitor
      median_verdict_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_verdicts.push_back(predict_verdict(op_type'(req_opcode), req_stamp,
                                                        req_now_time));
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("response beat with nothing expected: verdict %0d median_time %0h",
                      rsp_verdict, rsp_median_time);
               failed = 1'b1;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $error("verdict mismatch: expected %0d, actual %0d", want.verdict,
                         rsp_verdict);
                  failed = 1'b1;
               end
               if (rsp_median_time !== want.median) begin
                  $error("median_time mismatch: expected %0h, actual %0h", want.median,
                         rsp_median_time);
                  failed = 1'b1;
               end
            end
         end
         if (csr_wr_en) drift_limit = csr_wr_data;
      end
   end

   // response side: random short stalls, or one long hold-off when a test asks for it
   initial begin
      forever begin
         @(negedge clock);
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
            stall_len = 0;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offers one request beat and returns at the edge that accepts it; valid stays up
   // so back-to-back beats never drop it within one time step
   task automatic offer_header_beat(input op_type op, input logic [STAMP_W-1:0] stamp,
                                    input logic [STAMP_W-1:0] now);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_stamp <= stamp;
      req_now_time <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drops valid and waits until every expected response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      // pending and output stages, plus margin
      repeat (4) @(posedge clock);
   endtask

   task automatic write_drift(input logic [DRIFT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly a plausible header chain: appends creep forward with jitter, checks land
   // around the median and around the drift edge; the rest is clears and noise
   task automatic offer_chain_beat();
      int pick;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] now;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         chain_time = chain_time + $urandom_range(0, 1200) - 300;
         offer_header_beat(OP_APPEND, chain_time, $urandom);
      end else if (pick < 92) begin
         stamp = chain_time + $urandom_range(0, 1500) - $urandom_range(0, 5000);
         // half the checks sit within a few seconds of now plus drift
         if ($urandom_range(0, 1))
            now = stamp - drift_limit + $urandom_range(0, 8) - 4;
         else
            now = stamp + $urandom_range(0, 3000) - 1000;
         offer_header_beat(OP_CHECK, stamp, now);
      end else if (pick < 94) begin
         offer_header_beat(OP_CLEAR, $urandom, $urandom);
         chain_time = $urandom;
      end else if (pick < 96) begin
         offer_header_beat(OP_NONE, $urandom, $urandom);
      end else begin
         offer_header_beat(op_type'($urandom_range(0, 3)), $urandom, $urandom);
      end
   endtask

   // empty ring: check reports no ancestors, unused opcode reports done with zero median
   task automatic test_empty_ring();
      offer_header_beat(OP_CHECK, 32'd5, 32'd0);
      offer_header_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // extremes of the stamp, equal-to-median, the drift edge at default drift,
   // ring wrap and the unused opcode on a full ring
   task automatic test_window_extremes();
      int k;
      offer_header_beat(OP_APPEND, 32'hFFFF_FFFF, 32'd0);
      offer_header_beat(OP_APPEND, 32'd0, 32'hFFFF_FFFF);
      // two entries: upper median is the max, so an equal stamp is not after it
      offer_header_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // the tenth of these overwrites the oldest slot
      for (k = 1; k <= 10; k++) offer_header_beat(OP_APPEND, 32'(k * 100), 32'd0);
      offer_header_beat(OP_CHECK, 32'd501, 32'd0);
      offer_header_beat(OP_CHECK, 32'd500, 32'd0);
      offer_header_beat(OP_CHECK, 32'd7200, 32'd0);
      offer_header_beat(OP_CHECK, 32'd7201, 32'd0);
      // now plus drift goes past 32 bits
      offer_header_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_header_beat(OP_NONE, 32'd0, 32'd0);
   endtask

   // drift at zero and at its maximum, then clear and check the emptied ring
   task automatic test_drift_extremes();
      write_drift(16'd0);
      offer_header_beat(OP_CHECK, 32'd600, 32'd600);
      offer_header_beat(OP_CHECK, 32'd601, 32'd600);
      write_drift(16'hFFFF);
      offer_header_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_0001);
      offer_header_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFE_FFFF);
      offer_header_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_header_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic();
      int n;
      chain_time = $urandom;
      write_drift(16'($urandom_range(0, 65535)));
      for (n = 0; n < 400; n++) offer_chain_beat();
      write_drift(16'd0);
      for (n = 0; n < 300; n++) offer_chain_beat();
      write_drift(16'hFFFF);
      for (n = 0; n < 300; n++) offer_chain_beat();
      write_drift(DRIFT_RESET);
   endtask

   // response side holds off long enough for the pipeline to fill and stall requests
   task automatic test_backpressure();
      int n;
      stall_len = 64;
      for (n = 0; n < 60; n++) offer_chain_beat();
   endtask

   // request side stops until every response is back, then resumes
   task automatic test_pause_drain();
      int n;
      for (n = 0; n < 30; n++) offer_chain_beat();
      wait_drained();
      for (n = 0; n < 30; n++) offer_chain_beat();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_steady_stream();
      int n;
      write_drift(16'($urandom_range(0, 65535)));
      idle_on = 1'b0;
      for (n = 0; n < 500; n++) offer_chain_beat();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_window_extremes();
      test_drift_extremes();
      test_random_traffic();
      test_backpressure();
      test_pause_drain();
      test_steady_stream();
      wait_drained();
      repeat (8) @(posedge clock);
      if (!failed && expected_verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
